// ===== rtl/u8cw_pkg.sv =====
// shared types, constants and width functions for the utf-8 cell width decoder
package u8cw_pkg;

  localparam int unsigned OffsetBitsDefault = 16;
  localparam int unsigned NumSlots          = 4;

  localparam logic [6:0]  CellPixelWidthReset = 7'd8;
  localparam logic [20:0] ReplCp              = 21'h00FFFD;
  localparam logic [20:0] MaxScalar           = 21'h10FFFF;

  localparam logic [7:0] LeadMin   = 8'hC2;
  localparam logic [7:0] LeadE0    = 8'hE0;
  localparam logic [7:0] LeadED    = 8'hED;
  localparam logic [7:0] LeadF0    = 8'hF0;
  localparam logic [7:0] LeadF4    = 8'hF4;
  localparam logic [7:0] LeadLimit = 8'hF5;
  localparam logic [7:0] ContA0    = 8'hA0;
  localparam logic [7:0] Cont90    = 8'h90;

  localparam logic [2:0] CellsZero = 3'd0;
  localparam logic [2:0] CellsOne  = 3'd1;
  localparam logic [2:0] CellsTwo  = 3'd2;
  localparam logic [2:0] CellsTab  = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [15:0] start_offset;
    logic [2:0]  seq_bytes;
    logic [2:0]  cells;
    logic [8:0]  pixels;
    logic [17:0] running_cells;
    logic        run_last;
    logic        text_done;
  } out_item_t;

  typedef struct packed {
    logic [20:0] cp;
    logic [15:0] offset;
    logic [2:0]  len;
    logic [2:0]  cells;
  } slot_t;

  typedef struct packed {
    logic [2:0]                count;
    logic                      last_text;
    slot_t [NumSlots-1:0]      slot;
  } bundle_t;

  function automatic logic is_wide(logic [20:0] cp);
    return (cp inside {[21'h01100:21'h0115F], 21'h02329, 21'h0232A,
                       [21'h02E80:21'h0A4CF], [21'h0AC00:21'h0D7A3],
                       [21'h0F900:21'h0FAFF], [21'h20000:21'h3FFFD],
                       [21'h0FE10:21'h0FE19], [21'h0FE30:21'h0FE6F],
                       [21'h0FF00:21'h0FF60], [21'h0FFE0:21'h0FFE6]});
  endfunction

  function automatic logic [2:0] cells_of(logic [20:0] cp);
    logic [2:0] w;
    if (cp inside {21'h0, 21'h0A, 21'h0D}) begin
      w = CellsZero;
    end else if (cp == 21'h09) begin
      w = CellsTab;
    end else if (is_wide(cp)) begin
      w = CellsTwo;
    end else begin
      w = CellsOne;
    end
    return w;
  endfunction

endpackage

// ===== rtl/u8cw_decode.sv =====
// byte decoder: partial sequence state and the result bundle for one byte
module u8cw_decode #(
  parameter int unsigned OffsetBits = u8cw_pkg::OffsetBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  u8cw_pkg::in_item_t item_i,
  output u8cw_pkg::bundle_t bundle_o
);

  logic [7:0]            held_q [3];
  logic [7:0]            held_d [3];
  logic [1:0]            held_cnt_q, held_cnt_d;
  logic [1:0]            need_q, need_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] seq_q, seq_d;

  logic        active;
  logic        cont_ok;
  logic [7:0]  b;
  logic [20:0] cp_full;
  logic [2:0]  n;

  function automatic logic [OffsetBits-1:0] sat_off(logic [OffsetBits-1:0] base,
                                                    logic [1:0] inc);
    logic [OffsetBits:0] sum;
    sum = {1'b0, base} + (OffsetBits+1)'(inc);
    return sum[OffsetBits] ? '1 : sum[OffsetBits-1:0];
  endfunction

  function automatic u8cw_pkg::slot_t mk_slot(logic [20:0] cp,
                                             logic [OffsetBits-1:0] off,
                                             logic [2:0] len);
    u8cw_pkg::slot_t s;
    s.cp     = cp;
    s.offset = 16'(off);
    s.len    = len;
    s.cells  = u8cw_pkg::cells_of(cp);
    return s;
  endfunction

  assign b      = item_i.text_byte;
  assign active = (held_cnt_q != 2'd0) && (need_q != 2'd0);

  always_comb begin
    cont_ok = (b[7:6] == 2'b10);
    if (held_cnt_q == 2'd1) begin
      case (held_q[0])
        u8cw_pkg::LeadE0: if (b < u8cw_pkg::ContA0) cont_ok = 1'b0;
        u8cw_pkg::LeadED: if (b >= u8cw_pkg::ContA0) cont_ok = 1'b0;
        u8cw_pkg::LeadF0: if (b < u8cw_pkg::Cont90) cont_ok = 1'b0;
        u8cw_pkg::LeadF4: if (b >= u8cw_pkg::Cont90) cont_ok = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (held_cnt_q)
      2'd1:    cp_full = {10'b0, held_q[0][4:0], b[5:0]};
      2'd2:    cp_full = {5'b0, held_q[0][3:0], held_q[1][5:0], b[5:0]};
      2'd3:    cp_full = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]};
      default: cp_full = '0;
    endcase
  end

  always_comb begin
    bundle_o   = '0;
    n          = 3'd0;
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    need_d     = need_q;
    seq_d      = seq_q;
    pos_d      = item_i.end_of_text ? '0 : sat_off(pos_q, 2'd1);

    // broken sequence: one replacement per held byte
    if (active && !cont_ok) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < held_cnt_q) begin
          bundle_o.slot[n[1:0]] = mk_slot(u8cw_pkg::ReplCp, sat_off(seq_q, 2'(i)), 3'd1);
          n = n + 3'd1;
        end
      end
    end

    if (!active || !cont_ok) begin
      held_cnt_d = 2'd0;
      need_d     = 2'd0;
      if (!b[7]) begin
        bundle_o.slot[n[1:0]] = mk_slot({13'b0, b}, pos_q, 3'd1);
        n = n + 3'd1;
      end else if (b < u8cw_pkg::LeadMin || b >= u8cw_pkg::LeadLimit) begin
        bundle_o.slot[n[1:0]] = mk_slot(u8cw_pkg::ReplCp, pos_q, 3'd1);
        n = n + 3'd1;
      end else begin
        held_d[0]  = b;
        held_cnt_d = 2'd1;
        seq_d      = pos_q;
        need_d     = (b < u8cw_pkg::LeadE0) ? 2'd1 : ((b < u8cw_pkg::LeadF0) ? 2'd2 : 2'd3);
      end
    end else if (need_q > 2'd1) begin
      held_d[held_cnt_q] = b;
      held_cnt_d         = held_cnt_q + 2'd1;
      need_d             = need_q - 2'd1;
    end else begin
      bundle_o.slot[n[1:0]] = mk_slot(cp_full, seq_q, 3'(held_cnt_q) + 3'd1);
      n          = n + 3'd1;
      held_cnt_d = 2'd0;
      need_d     = 2'd0;
    end

    // truncated text
    if (item_i.end_of_text) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < held_cnt_d) begin
          bundle_o.slot[n[1:0]] = mk_slot(u8cw_pkg::ReplCp, sat_off(seq_d, 2'(i)), 3'd1);
          n = n + 3'd1;
        end
      end
      held_cnt_d = 2'd0;
      need_d     = 2'd0;
    end

    bundle_o.count     = n;
    bundle_o.last_text = item_i.end_of_text;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      need_q     <= 2'd0;
      pos_q      <= '0;
      seq_q      <= '0;
    end else if (load_i) begin
      held_cnt_q <= held_cnt_d;
      need_q     <= need_d;
      pos_q      <= pos_d;
      seq_q      <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== rtl/u8cw_result.sv =====
// result register: drains a bundle one item per handshake, keeps the cell total
module u8cw_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  u8cw_pkg::bundle_t   bundle_i,
  input  logic [6:0]          cell_pixel_width_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8cw_pkg::out_item_t out_item_o
);

  logic [2:0]                                count_q;
  logic                                      last_q;
  u8cw_pkg::slot_t [u8cw_pkg::NumSlots-1:0] slot_q;
  logic [17:0]       total_q, total_d;
  logic [18:0]       sum;
  logic              out_accept;
  u8cw_pkg::slot_t   head;

  assign head        = slot_q[0];
  assign out_valid_o = (count_q != 3'd0);
  assign out_accept  = out_valid_o && out_ready_i;
  assign can_load_o  = (count_q == 3'd0) || ((count_q == 3'd1) && out_ready_i);

  assign sum = {1'b0, total_q} + 19'(head.cells);

  always_comb begin
    out_item_o.code_point    = head.cp;
    out_item_o.start_offset  = head.offset;
    out_item_o.seq_bytes     = head.len;
    out_item_o.cells         = head.cells;
    out_item_o.running_cells = sum[18] ? '1 : sum[17:0];
    out_item_o.run_last      = (count_q == 3'd1);
    out_item_o.text_done     = (count_q == 3'd1) && last_q;
    case (head.cells)
      u8cw_pkg::CellsOne: out_item_o.pixels = {2'b0, cell_pixel_width_i};
      u8cw_pkg::CellsTwo: out_item_o.pixels = {1'b0, cell_pixel_width_i, 1'b0};
      u8cw_pkg::CellsTab: out_item_o.pixels = {cell_pixel_width_i, 2'b0};
      default:            out_item_o.pixels = '0;
    endcase
  end

  assign total_d = out_item_o.text_done ? '0 : out_item_o.running_cells;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
      total_q <= '0;
    end else begin
      if (out_accept) begin
        total_q <= total_d;
      end
      if (load_i) begin
        count_q <= bundle_i.count;
      end else if (out_accept) begin
        count_q <= count_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      last_q <= bundle_i.last_text;
      slot_q <= bundle_i.slot;
    end else if (out_accept) begin
      for (int i = 0; i < u8cw_pkg::NumSlots - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

endmodule

// ===== rtl/utf8_decode_cell_width.sv =====
// top level of the utf-8 decoder with cell width measurement
//
// input channel: one text byte per item with an end-of-text flag
// output channel: one item per code point with offset, length, cells,
// pixels and running cell total; run_last marks the final item of a byte,
// text_done the final item of the text
// config: cfg_we_i writes cfg_wdata_i into the pixels-per-cell register
// latency: an item's first result is valid the cycle after the byte is taken
// throughput: one byte per cycle while each byte gives at most one result and the
// receiver takes each result at once; a byte that gives more results holds the input
// until its last item leaves, since the result register hands its items out one per
// output handshake; bytes that only extend a sequence give no result
// reset: no sequence held, offsets and cell total at zero, pixel width 8
// stall: a stalled receiver keeps the result register full; one more byte
// is taken in the cycle its last item leaves
module utf8_decode_cell_width #(
  parameter int unsigned OffsetBits = u8cw_pkg::OffsetBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8cw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8cw_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i
);

  logic              in_accept;
  logic [6:0]        cpw_q;
  u8cw_pkg::bundle_t bundle;

  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpw_q <= u8cw_pkg::CellPixelWidthReset;
    end else if (cfg_we_i) begin
      cpw_q <= cfg_wdata_i;
    end
  end

  u8cw_decode #(
    .OffsetBits(OffsetBits)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_accept),
    .item_i  (in_item_i),
    .bundle_o(bundle)
  );

  u8cw_result u_result (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (in_accept),
    .bundle_i          (bundle),
    .cell_pixel_width_i(cpw_q),
    .can_load_o        (in_ready_o),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_item_o        (out_item_o)
  );

endmodule

// ===== rtl/u8cw_checker.sv =====
// port checker for the utf-8 cell width decoder and its bind
module u8cw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input u8cw_pkg::out_item_t out_item_o
);

  // item held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.code_point <= u8cw_pkg::MaxScalar)
    else $error("code point above scalar range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.text_done |-> out_item_o.run_last)
    else $error("text end not on last item of its byte");

  // multi-byte sequences never decode to ascii
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.seq_bytes != 3'd1 |-> out_item_o.code_point >= 21'h80)
    else $error("overlong sequence accepted");

endmodule

bind utf8_decode_cell_width u8cw_checker u_chk (.*);

// ===== test/tb_utf8_decode_cell_width.sv =====
// testbench for utf8_decode_cell_width: directed and random byte streams checked against a predictor
module tb_utf8_decode_cell_width;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned OffsetMax     = (1 << u8cw_pkg::OffsetBitsDefault) - 1;
  localparam int unsigned CellMax       = 262143;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseBytes    = 30;

  logic                clk_i;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  u8cw_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  u8cw_pkg::out_item_t out_item;
  logic                cfg_we    = 1'b0;
  logic [6:0]          cfg_wdata = '0;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned errors    = 0;
  int unsigned bytes_sent = 0;

  // decoder state as the predictor sees it
  logic [7:0]  held_q [3];
  int unsigned held_n      = 0;
  int unsigned need_n      = 0;
  int unsigned next_pos    = 0;
  int unsigned cell_sum    = 0;
  int unsigned seq_off     = 0;
  logic [6:0]  px_per_cell = u8cw_pkg::CellPixelWidthReset;

  u8cw_pkg::out_item_t pending_glyphs[$];

  int unsigned boundary_cps[$] = '{
    'h00, 'h09, 'h0A, 'h0D, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF,
    'h10000, 'h10FFFF, 'h10FF, 'h1100, 'h115F, 'h1160, 'h2328, 'h2329, 'h232A,
    'h232B, 'h2E7F, 'h2E80, 'hA4CF, 'hA4D0, 'hABFF, 'hAC00, 'hD7A3, 'hD7A4,
    'hF8FF, 'hF900, 'hFAFF, 'hFB00, 'h1FFFF, 'h20000, 'h3FFFD, 'h3FFFE,
    'hFE0F, 'hFE10, 'hFE19, 'hFE1A, 'hFE2F, 'hFE30, 'hFE6F, 'hFE70, 'hFEFF,
    'hFF00, 'hFF60, 'hFF61, 'hFFDF, 'hFFE0, 'hFFE6, 'hFFE7
  };

  utf8_decode_cell_width i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void flag(string msg);
    errors++;
    if (errors <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      flag($sformatf("%s expected %0h, got %0h", name, want, got));
    end
  endfunction

  function automatic int unsigned sat_offset(int unsigned v);
    return (v > OffsetMax) ? OffsetMax : v;
  endfunction

  function automatic logic [2:0] glyph_cells(logic [20:0] cp);
    if (cp == 21'h0 || cp == 21'h0A || cp == 21'h0D) return u8cw_pkg::CellsZero;
    if (cp == 21'h09) return u8cw_pkg::CellsTab;
    if ((cp >= 21'h1100 && cp <= 21'h115F) || cp == 21'h2329 || cp == 21'h232A ||
        (cp >= 21'h2E80 && cp <= 21'hA4CF) || (cp >= 21'hAC00 && cp <= 21'hD7A3) ||
        (cp >= 21'hF900 && cp <= 21'hFAFF) || (cp >= 21'h20000 && cp <= 21'h3FFFD) ||
        (cp >= 21'hFE10 && cp <= 21'hFE19) || (cp >= 21'hFE30 && cp <= 21'hFE6F) ||
        (cp >= 21'hFF00 && cp <= 21'hFF60) || (cp >= 21'hFFE0 && cp <= 21'hFFE6)) begin
      return u8cw_pkg::CellsTwo;
    end
    return u8cw_pkg::CellsOne;
  endfunction

  function automatic void emit_glyph(logic [20:0] cp, int unsigned off, logic [2:0] len);
    u8cw_pkg::out_item_t g;
    logic [2:0]          c;
    c = glyph_cells(cp);
    cell_sum = (cell_sum + c > CellMax) ? CellMax : cell_sum + c;
    g.code_point    = cp;
    g.start_offset  = 16'(off);
    g.seq_bytes     = len;
    g.cells         = c;
    g.pixels        = 9'(int'(c) * int'(px_per_cell));
    g.running_cells = 18'(cell_sum);
    g.run_last      = 1'b0;
    g.text_done     = 1'b0;
    pending_glyphs.push_back(g);
  endfunction

  function automatic void flush_held();
    for (int unsigned i = 0; i < held_n; i++) begin
      emit_glyph(u8cw_pkg::ReplCp, sat_offset(seq_off + i), 3'd1);
    end
    held_n = 0;
    need_n = 0;
  endfunction

  function automatic void start_seq(logic [7:0] b, int unsigned off);
    if (b < 8'h80) begin
      emit_glyph(21'(b), off, 3'd1);
    end else if (b < u8cw_pkg::LeadMin || b >= u8cw_pkg::LeadLimit) begin
      emit_glyph(u8cw_pkg::ReplCp, off, 3'd1);
    end else begin
      held_q[0] = b;
      held_n    = 1;
      seq_off   = off;
      need_n    = (b < u8cw_pkg::LeadE0) ? 1 : ((b < u8cw_pkg::LeadF0) ? 2 : 3);
    end
  endfunction

  function automatic void decode_text_byte(logic [7:0] b, logic eot);
    int unsigned off;
    int unsigned first;
    int unsigned total;
    logic [20:0] cp;
    logic        ok;
    first    = pending_glyphs.size();
    off      = next_pos;
    next_pos = sat_offset(next_pos + 1);
    if (held_n == 0) begin
      start_seq(b, off);
    end else begin
      ok = (b[7:6] == 2'b10);
      if (ok && held_n == 1) begin
        if (held_q[0] == u8cw_pkg::LeadE0 && b < u8cw_pkg::ContA0) ok = 1'b0;
        if (held_q[0] == u8cw_pkg::LeadED && b >= u8cw_pkg::ContA0) ok = 1'b0;
        if (held_q[0] == u8cw_pkg::LeadF0 && b < u8cw_pkg::Cont90) ok = 1'b0;
        if (held_q[0] == u8cw_pkg::LeadF4 && b >= u8cw_pkg::Cont90) ok = 1'b0;
      end
      if (!ok) begin
        flush_held();
        start_seq(b, off);
      end else if (need_n > 1) begin
        held_q[held_n] = b;
        held_n++;
        need_n--;
      end else begin
        total = held_n + 1;
        case (total)
          2: cp = 21'(held_q[0][4:0]);
          3: cp = 21'(held_q[0][3:0]);
          default: cp = 21'(held_q[0][2:0]);
        endcase
        for (int unsigned i = 1; i < held_n; i++) begin
          cp = (cp << 6) | 21'(held_q[i][5:0]);
        end
        cp = (cp << 6) | 21'(b[5:0]);
        emit_glyph(cp, seq_off, 3'(total));
        held_n = 0;
        need_n = 0;
      end
    end
    if (eot) begin
      flush_held();
      next_pos = 0;
      cell_sum = 0;
    end
    if (pending_glyphs.size() > first) begin
      pending_glyphs[pending_glyphs.size() - 1].run_last  = 1'b1;
      pending_glyphs[pending_glyphs.size() - 1].text_done = eot;
    end
  endfunction

  function automatic byte_q_t utf8_encode(logic [20:0] cp);
    byte_q_t s;
    if (cp < 21'h80) begin
      s = '{cp[7:0]};
    end else if (cp < 21'h800) begin
      s = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
    end else if (cp < 21'h10000) begin
      s = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    end else begin
      s = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
            {2'b10, cp[5:0]}};
    end
    return s;
  endfunction

  function automatic logic [20:0] pick_scalar();
    logic [20:0] cp;
    case ($urandom_range(9))
      0: cp = 21'($urandom_range('h80, 'h7FF));
      1: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp -= 21'h800;
      end
      2: cp = 21'($urandom_range('h10000, 'h10FFFF));
      3, 4, 5: cp = 21'(boundary_cps[$urandom_range(boundary_cps.size() - 1)]);
      default: cp = 21'($urandom_range(0, 'h7F));
    endcase
    return cp;
  endfunction

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_glyphs
    u8cw_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_glyphs.size() == 0) begin
        flag($sformatf("unexpected item, code_point %0h", out_item.code_point));
      end else begin
        want = pending_glyphs.pop_front();
        check_field("code_point", want.code_point, out_item.code_point);
        check_field("start_offset", want.start_offset, out_item.start_offset);
        check_field("seq_bytes", want.seq_bytes, out_item.seq_bytes);
        check_field("cells", want.cells, out_item.cells);
        check_field("pixels", want.pixels, out_item.pixels);
        check_field("running_cells", want.running_cells, out_item.running_cells);
        check_field("run_last", want.run_last, out_item.run_last);
        check_field("text_done", want.text_done, out_item.text_done);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, logic eot);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{text_byte: b, end_of_text: eot};
    do @(posedge clk_i); while (!in_ready);
    decode_text_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_seq(byte_q_t s, logic eot_last);
    foreach (s[i]) begin
      send_byte(s[i], eot_last && (i == s.size() - 1));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cell_px(logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    px_per_cell = v;
  endtask

  task automatic test_single_bytes();
    send_seq('{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h41, 8'h7F}, 1'b1);
  endtask

  task automatic test_sequences();
    send_seq('{8'hC2, 8'h80, 8'hE1, 8'h84, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);
  endtask

  task automatic test_malformed();
    // stray continuation, bad leads, overlong, surrogate, above range, early break
    send_seq('{8'h80, 8'hC1, 8'hF5, 8'hFF, 8'hE0, 8'h80, 8'hED, 8'hA0,
               8'hF0, 8'h8F, 8'hF4, 8'h90, 8'hC2, 8'h41}, 1'b1);
  endtask

  task automatic test_truncated_text();
    send_seq('{8'hE1, 8'h80}, 1'b1);
  endtask

  task automatic test_pixel_width();
    logic [6:0] widths[$];
    widths = '{7'd1, 7'd64, 7'd0, 7'd127};
    foreach (widths[i]) begin
      wait_idle();
      write_cell_px(widths[i]);
      send_seq('{8'h09, 8'hE1, 8'h84, 8'h80, 8'h41}, 1'b1);
    end
  endtask

  task automatic test_random_text();
    int unsigned gaps[4]   = '{0, 48, 0, 6};
    int unsigned stalls[4] = '{0, 0, 48, 6};
    int unsigned start;
    int unsigned pick;
    byte_q_t     s;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_cell_px(7'($urandom_range(1, 64)));
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      start     = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
        pick = $urandom_range(99);
        s    = utf8_encode(pick_scalar());
        if (pick < 70) begin
          send_seq(s, $urandom_range(15) == 0);
        end else if (pick < 80) begin
          send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end else if (pick < 90) begin
          // cut short, then either end of text or a fresh byte breaks it
          if (s.size() > 1) begin
            repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
          end
          send_seq(s, 1'($urandom_range(1)));
        end else begin
          if (s.size() > 1) begin
            s[$urandom_range(1, s.size() - 1)] = 8'($urandom_range(255));
          end
          send_seq(s, $urandom_range(7) == 0);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_single_bytes();
    test_sequences();
    test_malformed();
    test_truncated_text();
    test_pixel_width();
    test_random_text();
    wait_idle();
    if (errors == 0 && pending_glyphs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
